// ----- rtl/core/sabq_pkg.sv -----
package sabq_pkg;

	// grid limits (defaults for the top-level parameters)
	localparam int MAX_GRID_WIDTH  = 64;
	localparam int MAX_GRID_HEIGHT = 64;

	// field widths
	localparam int IDX_W      = 13;
	localparam int VAL_W      = 13;
	localparam int COUNT_W    = 13;
	localparam int COORD_W    = 32;
	localparam int RAD_W      = 24;
	localparam int ORIGIN_W   = 16;
	localparam int GRID_W     = 7;
	localparam int CS_W       = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int COUNT_MAX = 8191;
	// largest value the cell size register holds
	localparam int CELL_MAX  = (1 << CS_W) - 1;

	// coordinate after the divide by 16, origin product, and offset numerator
	localparam int FDIV_W = COORD_W - 3;
	localparam int PROD_W = ORIGIN_W + CS_W + 1;
	localparam int NUM_W  = 31;
	// corner sum: two adds and two subtracts of table words
	localparam int ACC_W  = VAL_W + 2;

	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 3'd4;

	localparam logic [CS_W-1:0] CELL_SIZE_RESET = 9'd32;

	// operation codes of an input word
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// kinds of work handed from front to back
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_ZERO  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [ORIGIN_W-1:0] origin_x;
		logic [ORIGIN_W-1:0] origin_y;
		logic [GRID_W-1:0]   grid_width;
		logic [GRID_W-1:0]   grid_height;
		logic [CS_W-1:0]     cell_size;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       wr_en;
	} qctrl_t;

	localparam int QCTRL_W = $bits(qctrl_t);

endpackage

// ----- rtl/core/sabq_fifo.sv -----
module sabq_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = sabq_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/sabq_front.sv -----
module sabq_front #(
	parameter int MAX_GRID_WIDTH  = sabq_pkg::MAX_GRID_WIDTH,
	parameter int MAX_GRID_HEIGHT = sabq_pkg::MAX_GRID_HEIGHT,
	localparam int DEPTH = (MAX_GRID_WIDTH + 1) * (MAX_GRID_HEIGHT + 1),
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sabq_pkg::cfg_t                     cfg,
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [sabq_pkg::IDX_W-1:0]         entry_index,
	input  logic [sabq_pkg::VAL_W-1:0]         entry_value,
	input  logic signed [sabq_pkg::COORD_W-1:0] light_x,
	input  logic signed [sabq_pkg::COORD_W-1:0] light_y,
	input  logic [sabq_pkg::RAD_W-1:0]         light_radius,
	output logic                               q_push,
	input  logic                               q_full,
	output sabq_pkg::qctrl_t                   q_ctrl,
	output logic [3:0][AW-1:0]                 q_addr,
	output logic [sabq_pkg::VAL_W-1:0]         q_value
);

	localparam int GMAX = (MAX_GRID_WIDTH > MAX_GRID_HEIGHT) ? MAX_GRID_WIDTH : MAX_GRID_HEIGHT;
	localparam int CAP  = GMAX + 1;
	localparam int QW   = $clog2(CAP + 1);
	localparam int DW   = $clog2((CAP + 1) * sabq_pkg::CELL_MAX + 1);
	localparam int BW   = QW + 3;
	localparam int PW   = QW + 1;
	localparam int CNTW = $clog2(QW);
	localparam int CW   = sabq_pkg::COORD_W + 1;
	localparam int FW   = sabq_pkg::FDIV_W;
	localparam int NW   = sabq_pkg::NUM_W;
	localparam int RW   = sabq_pkg::PROD_W;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_PROD = 3'd1;
	localparam logic [2:0] F_SUB  = 3'd2;
	localparam logic [2:0] F_CLS  = 3'd3;
	localparam logic [2:0] F_DIV  = 3'd4;
	localparam logic [2:0] F_BOX  = 3'd5;
	localparam logic [2:0] F_ROW  = 3'd6;
	localparam logic [2:0] F_PUSH = 3'd7;

	logic [2:0]                       state_q;
	logic [1:0]                       kind_q;
	logic                             wr_en_q;
	logic [sabq_pkg::IDX_W-1:0]       idx_q;
	logic [sabq_pkg::VAL_W-1:0]       val_q;
	logic signed [sabq_pkg::COORD_W-1:0] lx_q;
	logic signed [sabq_pkg::COORD_W-1:0] ly_q;
	logic [sabq_pkg::RAD_W-1:0]       rad_q;
	logic signed [FW-1:0]             f_q [4];
	logic signed [RW-1:0]             prod_x_q;
	logic signed [RW-1:0]             prod_y_q;
	logic [DW-1:0]                    capcs_q;
	logic signed [NW-1:0]             n_q [4];
	logic                             lo_sat_q [4];
	logic                             hi_sat_q [4];
	logic [DW-1:0]                    rem_q [4];
	logic [QW-1:0]                    quo_q [4];
	logic [DW-1:0]                    dsh_q;
	logic [CNTW-1:0]                  cnt_q;
	logic [QW-1:0]                    fx_q;
	logic [QW-1:0]                    fy_q;
	logic [QW-1:0]                    lx1_q;
	logic [QW-1:0]                    ly1_q;
	logic [AW-1:0]                    row0_q;
	logic [AW-1:0]                    row1_q;

	logic [sabq_pkg::CS_W-1:0] cs_eff;
	logic [QW-1:0]             w_eff;
	logic [QW-1:0]             h_eff;
	logic [PW-1:0]             pw;
	logic                      accept;
	logic                      no_query;

	logic [CW-1:0]        v [4];
	logic signed [NW-1:0] csn;
	logic signed [NW-1:0] np [4];
	logic signed [NW-1:0] capn;
	logic                 ge [4];
	logic signed [BW-1:0] sq [4];
	logic signed [BW-1:0] lim [2];
	logic signed [BW-1:0] lo [2];
	logic signed [BW-1:0] hi [2];
	logic                 empty_box;

	assign cs_eff = (cfg.cell_size == '0) ? sabq_pkg::CS_W'(1) : cfg.cell_size;
	assign w_eff  = (32'(cfg.grid_width) > MAX_GRID_WIDTH) ? QW'(MAX_GRID_WIDTH)
	                                                       : QW'(cfg.grid_width);
	assign h_eff  = (32'(cfg.grid_height) > MAX_GRID_HEIGHT) ? QW'(MAX_GRID_HEIGHT)
	                                                         : QW'(cfg.grid_height);
	assign pw     = PW'(w_eff) + PW'(1);

	assign full     = (state_q != F_IDLE);
	assign accept   = push && !full;
	assign no_query = (light_radius == '0) || (w_eff == '0) || (h_eff == '0);

	// lanes: 0 x low, 1 x high, 2 y low, 3 y high
	always_comb begin
		v[0] = CW'(lx_q) - CW'(rad_q);
		v[1] = CW'(lx_q) + CW'(rad_q);
		v[2] = CW'(ly_q) - CW'(rad_q);
		v[3] = CW'(ly_q) + CW'(rad_q);
		csn  = $signed(NW'(cs_eff));
		capn = $signed(NW'(capcs_q));
		for (int k = 0; k < 4; k++) begin
			np[k] = n_q[k] + csn;
			ge[k] = (rem_q[k] >= dsh_q);
		end
	end

	// quotient relative to the origin, saturated to the range that matters
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (lo_sat_q[k]) begin
				sq[k] = BW'(-2);
			end else if (hi_sat_q[k]) begin
				sq[k] = BW'(CAP);
			end else begin
				sq[k] = $signed(BW'(quo_q[k])) - BW'(1);
			end
		end
		lim[0] = $signed(BW'(w_eff)) - BW'(1);
		lim[1] = $signed(BW'(h_eff)) - BW'(1);
		for (int a = 0; a < 2; a++) begin
			lo[a] = sq[2 * a] - BW'(1);
			if (lo[a] < 0) begin
				lo[a] = '0;
			end
			hi[a] = sq[2 * a + 1] + BW'(1);
			if (hi[a] > lim[a]) begin
				hi[a] = lim[a];
			end
		end
		empty_box = (lo[0] > hi[0]) || (lo[1] > hi[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (operation == sabq_pkg::OP_WRITE || no_query) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_PROD;
						end
					end
				end
				F_PROD: state_q <= F_SUB;
				F_SUB:  state_q <= F_CLS;
				F_CLS: begin
					cnt_q   <= CNTW'(QW - 1);
					state_q <= F_DIV;
				end
				F_DIV: begin
					if (cnt_q == '0) begin
						state_q <= F_BOX;
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				F_BOX:  state_q <= empty_box ? F_PUSH : F_ROW;
				F_ROW:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					idx_q   <= entry_index;
					val_q   <= entry_value;
					lx_q    <= light_x;
					ly_q    <= light_y;
					rad_q   <= light_radius;
					wr_en_q <= (32'(entry_index) < DEPTH);
					if (operation == sabq_pkg::OP_WRITE) begin
						kind_q <= sabq_pkg::KIND_WRITE;
					end else if (no_query) begin
						kind_q <= sabq_pkg::KIND_ZERO;
					end else begin
						kind_q <= sabq_pkg::KIND_QUERY;
					end
				end
			end
			F_PROD: begin
				// floor divide by 16 is the arithmetic shift
				for (int k = 0; k < 4; k++) begin
					f_q[k] <= v[k][CW-1:4];
				end
				prod_x_q <= $signed(cfg.origin_x) * $signed({1'b0, cs_eff});
				prod_y_q <= $signed(cfg.origin_y) * $signed({1'b0, cs_eff});
				capcs_q  <= DW'(CAP + 1) * DW'(cs_eff);
			end
			F_SUB: begin
				n_q[0] <= NW'(f_q[0]) - NW'(prod_x_q);
				n_q[1] <= NW'(f_q[1]) - NW'(prod_x_q);
				n_q[2] <= NW'(f_q[2]) - NW'(prod_y_q);
				n_q[3] <= NW'(f_q[3]) - NW'(prod_y_q);
			end
			F_CLS: begin
				for (int k = 0; k < 4; k++) begin
					lo_sat_q[k] <= (n_q[k] < -csn);
					hi_sat_q[k] <= (np[k] >= capn);
					rem_q[k]    <= DW'(np[k]);
					quo_q[k]    <= '0;
				end
				dsh_q <= DW'(cs_eff) << (QW - 1);
			end
			F_DIV: begin
				for (int k = 0; k < 4; k++) begin
					if (ge[k]) begin
						rem_q[k] <= rem_q[k] - dsh_q;
					end
					quo_q[k] <= {quo_q[k][QW-2:0], ge[k]};
				end
				dsh_q <= dsh_q >> 1;
			end
			F_BOX: begin
				if (empty_box) begin
					kind_q <= sabq_pkg::KIND_ZERO;
				end
				fx_q  <= QW'(lo[0]);
				fy_q  <= QW'(lo[1]);
				lx1_q <= QW'(hi[0] + BW'(1));
				ly1_q <= QW'(hi[1] + BW'(1));
			end
			F_ROW: begin
				row0_q <= AW'(fy_q) * AW'(pw);
				row1_q <= AW'(ly1_q) * AW'(pw);
			end
			default: begin
			end
		endcase
	end

	assign q_push       = (state_q == F_PUSH) && !q_full;
	assign q_ctrl.kind  = kind_q;
	assign q_ctrl.wr_en = wr_en_q;
	assign q_value      = val_q;

	// corners 0 and 1 add, corners 2 and 3 subtract
	always_comb begin
		if (kind_q == sabq_pkg::KIND_WRITE) begin
			q_addr[0] = AW'(idx_q);
		end else begin
			q_addr[0] = row1_q + AW'(lx1_q);
		end
		q_addr[1] = row0_q + AW'(fx_q);
		q_addr[2] = row0_q + AW'(lx1_q);
		q_addr[3] = row1_q + AW'(fx_q);
	end

endmodule

// ----- rtl/core/sabq_back.sv -----
module sabq_back #(
	parameter int MAX_GRID_WIDTH  = sabq_pkg::MAX_GRID_WIDTH,
	parameter int MAX_GRID_HEIGHT = sabq_pkg::MAX_GRID_HEIGHT,
	localparam int DEPTH = (MAX_GRID_WIDTH + 1) * (MAX_GRID_HEIGHT + 1),
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  sabq_pkg::qctrl_t             q_ctrl,
	input  logic [3:0][AW-1:0]           q_addr,
	input  logic [sabq_pkg::VAL_W-1:0]   q_value,
	output logic                         empty,
	input  logic                         pop,
	output logic                         occupied,
	output logic [sabq_pkg::COUNT_W-1:0] cell_count
);

	localparam int AC = sabq_pkg::ACC_W;
	localparam int VW = sabq_pkg::VAL_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_EMIT = 2'd2;

	logic [VW-1:0]                mem [DEPTH];
	logic [1:0]                   state_q;
	logic [2:0]                   cnt_q;
	logic [AW-1:0]                addr_q [4];
	logic [VW-1:0]                rd_data_q;
	logic signed [AC-1:0]         acc_q;
	logic                         out_valid_q;
	logic                         occ_q;
	logic [sabq_pkg::COUNT_W-1:0] count_q;

	logic                 mem_we;
	logic                 mem_re;
	logic                 load;
	logic signed [AC-1:0] rd_ext;

	assign q_pop  = (state_q == B_IDLE) && !q_empty;
	assign mem_we = q_pop && (q_ctrl.kind == sabq_pkg::KIND_WRITE) && q_ctrl.wr_en;
	assign mem_re = (state_q == B_READ) && !cnt_q[2];
	assign load   = (state_q == B_EMIT) && (!out_valid_q || pop);
	assign rd_ext = $signed(AC'(rd_data_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_addr[0]] <= q_value;
		end
		if (mem_re) begin
			rd_data_q <= mem[addr_q[cnt_q[1:0]]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						cnt_q   <= '0;
						state_q <= (q_ctrl.kind == sabq_pkg::KIND_QUERY) ? B_READ : B_EMIT;
					end
				end
				B_READ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q[2]) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			acc_q <= '0;
			for (int k = 0; k < 4; k++) begin
				addr_q[k] <= q_addr[k];
			end
		end
		// read data arrives in the cycle after its address is given
		if (state_q == B_READ && cnt_q != '0) begin
			if (cnt_q <= 3'd2) begin
				acc_q <= acc_q + rd_ext;
			end else begin
				acc_q <= acc_q - rd_ext;
			end
		end
		if (load) begin
			occ_q <= (acc_q > 0);
			if (acc_q <= 0) begin
				count_q <= '0;
			end else if (acc_q > sabq_pkg::COUNT_MAX) begin
				count_q <= sabq_pkg::COUNT_W'(sabq_pkg::COUNT_MAX);
			end else begin
				count_q <= acc_q[sabq_pkg::COUNT_W-1:0];
			end
		end
	end

	assign empty      = !out_valid_q;
	assign occupied   = occ_q;
	assign cell_count = count_q;

endmodule

// ----- rtl/core/summed_area_box_occupancy_query_top.sv -----
// Summed-area box occupancy query.
// Holds a prefix-count table of (grid_width+1) x (grid_height+1) entries and
// answers light queries against it. Every input word gives one result word,
// in order: a write (operation 0) stores entry_value at entry_index and
// returns zeros; a query (operation 1) returns the cell count of the clamped
// box around the light and whether it is nonzero.
// Input: a word is taken when push is high and full is low. Results: the
// oldest word shows while empty is low and leaves when pop is high.
// Configuration: cfg_ready is always high; write only while the block is idle.
// The front moves a write from idle straight to push. A query first runs
// the product, subtract, classify, divide, box and row states (a zero
// radius or grid goes straight to push, an empty box skips the row state);
// the four-lane divider retires one quotient bit per cycle. The back reads
// the four corners through the one table port, so the front sets the rate.
// A two-word queue sits between front and back; when pop stays low, the
// result register, the back and the queue fill in turn and full stays high.
// Reset clears the control state and loads the register defaults (cell size
// 32, everything else 0); table entries are undefined until written and need
// no clearing pass.
module summed_area_box_occupancy_query_top #(
	parameter int MAX_GRID_WIDTH  = sabq_pkg::MAX_GRID_WIDTH,
	parameter int MAX_GRID_HEIGHT = sabq_pkg::MAX_GRID_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sabq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sabq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic                                operation,
	input  logic [sabq_pkg::IDX_W-1:0]          entry_index,
	input  logic [sabq_pkg::VAL_W-1:0]          entry_value,
	input  logic signed [sabq_pkg::COORD_W-1:0] light_x,
	input  logic signed [sabq_pkg::COORD_W-1:0] light_y,
	input  logic [sabq_pkg::RAD_W-1:0]          light_radius,
	output logic                                empty,
	input  logic                                pop,
	output logic                                occupied,
	output logic [sabq_pkg::COUNT_W-1:0]        cell_count
);

	localparam int DEPTH = (MAX_GRID_WIDTH + 1) * (MAX_GRID_HEIGHT + 1);
	localparam int AW    = $clog2(DEPTH);
	localparam int QDW   = sabq_pkg::QCTRL_W + 4 * AW + sabq_pkg::VAL_W;

	sabq_pkg::cfg_t cfg_q;

	logic                       f_push;
	logic                       q_full;
	sabq_pkg::qctrl_t           f_ctrl;
	logic [3:0][AW-1:0]         f_addr;
	logic [sabq_pkg::VAL_W-1:0] f_value;
	logic [QDW-1:0]             q_wdata;
	logic [QDW-1:0]             q_rdata;
	logic                       q_empty;
	logic                       q_pop;
	sabq_pkg::qctrl_t           b_ctrl;
	logic [3:0][AW-1:0]         b_addr;
	logic [sabq_pkg::VAL_W-1:0] b_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.grid_width  <= '0;
			cfg_q.grid_height <= '0;
			cfg_q.cell_size   <= sabq_pkg::CELL_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sabq_pkg::CFG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data;
				sabq_pkg::CFG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data;
				sabq_pkg::CFG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data[sabq_pkg::GRID_W-1:0];
				sabq_pkg::CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_data[sabq_pkg::GRID_W-1:0];
				sabq_pkg::CFG_CELL_SIZE:   cfg_q.cell_size   <= cfg_data[sabq_pkg::CS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sabq_front #(
		.MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
		.MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.light_x      (light_x),
		.light_y      (light_y),
		.light_radius (light_radius),
		.q_push       (f_push),
		.q_full       (q_full),
		.q_ctrl       (f_ctrl),
		.q_addr       (f_addr),
		.q_value      (f_value)
	);

	assign q_wdata = {f_ctrl, f_addr, f_value};

	sabq_fifo #(
		.W     (QDW),
		.DEPTH (sabq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign {b_ctrl, b_addr, b_value} = q_rdata;

	sabq_back #(
		.MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
		.MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_ctrl     (b_ctrl),
		.q_addr     (b_addr),
		.q_value    (b_value),
		.empty      (empty),
		.pop        (pop),
		.occupied   (occupied),
		.cell_count (cell_count)
	);

	a_occupied_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (occupied == (cell_count != '0)))
		else $error("occupied flag disagrees with cell count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front took a word but did not go busy");

	a_queue_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back popped an empty queue");

endmodule
